/* rtl/csbe_pkg.sv */
// Shared types, codes and fixed-point helpers for the cubic spline bank evaluator.
package csbe_pkg;

    localparam int Q_W       = 32;
    localparam int COEFFS    = 4;
    localparam int ROW_W     = Q_W * COEFFS;
    localparam int SPL_OUT_W = 6;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // Input commands.
    localparam logic [1:0] CMD_EVAL      = 2'd0;
    localparam logic [1:0] CMD_LOAD_COEF = 2'd1;
    localparam logic [1:0] CMD_LOAD_KNOT = 2'd2;

    // Position of each coefficient within a memory row.
    localparam int COEF_Y = 0;
    localparam int COEF_B = 1;
    localparam int COEF_C = 2;
    localparam int COEF_D = 3;

    typedef struct packed {
        logic [SPL_OUT_W-1:0] spline;
        logic                 last;
    } tag_t;

    // Saturate a 33-bit sum or difference to Q16.16.
    function automatic logic signed [Q_W-1:0] q_sat33(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1])
            r = v[Q_W] ? Q_MIN : Q_MAX;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] q_add(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        return q_sat33(s);
    endfunction

    // Drop 16 fraction bits of a full product (floor) and saturate.
    function automatic logic signed [Q_W-1:0] q_scale(input logic signed [2*Q_W-1:0] p);
        logic [47:0]           sh;
        logic signed [Q_W-1:0] r;
        sh = p[63:16];
        if ((&sh[47:31]) || !(|sh[47:31]))
            r = sh[31:0];
        else
            r = sh[47] ? Q_MIN : Q_MAX;
        return r;
    endfunction

endpackage

/* rtl/csbe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module csbe_ram
    #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/csbe_horner.sv */
// Pipelined Horner evaluation of one spline row per cycle while adv is high, with the output register.
module csbe_horner
    import csbe_pkg::*;
    (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  issue_valid,
    input  tag_t                  issue_tag,
    input  logic [ROW_W-1:0]      row,
    input  logic signed [Q_W-1:0] dx,
    output logic                  busy,
    output logic                  out_valid,
    output tag_t                  out_tag,
    output logic signed [Q_W-1:0] weight
    );

    localparam int NST = 7;

    logic                    v_reg   [NST];
    tag_t                    tag_reg [NST];

    logic signed [Q_W-1:0]   c1_reg, b1_reg, y1_reg;
    logic signed [2*Q_W-1:0] prod1_reg;
    logic signed [Q_W-1:0]   t2_reg, b2_reg, y2_reg;
    logic signed [2*Q_W-1:0] prod3_reg;
    logic signed [Q_W-1:0]   b3_reg, y3_reg;
    logic signed [Q_W-1:0]   t4_reg, y4_reg;
    logic signed [2*Q_W-1:0] prod5_reg;
    logic signed [Q_W-1:0]   y5_reg;
    logic signed [Q_W-1:0]   weight_reg;

    logic signed [Q_W-1:0]   row_y, row_b, row_c, row_d;

    assign row_y = row[Q_W*COEF_Y +: Q_W];
    assign row_b = row[Q_W*COEF_B +: Q_W];
    assign row_c = row[Q_W*COEF_C +: Q_W];
    assign row_d = row[Q_W*COEF_D +: Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= issue_valid;
            for (int i = 1; i < NST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Stage 0 sits alongside the memory read register; the row arrives with it.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= issue_tag;
            for (int i = 1; i < NST; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            prod1_reg  <= dx * row_d;
            c1_reg     <= row_c;
            b1_reg     <= row_b;
            y1_reg     <= row_y;
            t2_reg     <= q_add(c1_reg, q_scale(prod1_reg));
            b2_reg     <= b1_reg;
            y2_reg     <= y1_reg;
            prod3_reg  <= dx * t2_reg;
            b3_reg     <= b2_reg;
            y3_reg     <= y2_reg;
            t4_reg     <= q_add(b3_reg, q_scale(prod3_reg));
            y4_reg     <= y3_reg;
            prod5_reg  <= dx * t4_reg;
            y5_reg     <= y4_reg;
            weight_reg <= q_add(y5_reg, q_scale(prod5_reg));
        end
    end

    always_comb
    begin
        busy = 1'b0;
        for (int i = 0; i < NST - 1; i++)
        begin
            busy = busy | v_reg[i];
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_tag   = tag_reg[NST-1];
    assign weight    = weight_reg;

endmodule

/* rtl/cubic_spline_bank_evaluator.sv */
// Top level of the cubic spline bank evaluator: command sequencer and memories.
//
// The block keeps NUM_SPLINES cubic splines on one grid of NUM_KNOTS knots.
// Coefficients Y, B, C, D of one spline and knot share one row of the
// coefficient memory; knot positions sit in a second small memory. Neither
// memory is cleared at reset, so every entry must be loaded before an
// evaluation reads it. A coefficient load reads the row, merges the new
// value in and writes the row back. An evaluate transaction reads the
// knot position, forms dx, then reads one coefficient row per cycle while
// out_stall does not hold the pipeline, through the single read port of
// the coefficient memory; the Horner pipeline then drains before the
// next transaction is taken. Results leave in spline order, one per cycle
// while out_stall stays low, and last_weight marks the final spline.
module cubic_spline_bank_evaluator
    import csbe_pkg::*;
    #(
    parameter int NUM_SPLINES = 64,
    parameter int NUM_KNOTS   = 16
    )
    (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [5:0]            spline_index,
    input  logic [3:0]            knot_index,
    input  logic [1:0]            coeff_select,
    input  logic [3:0]            segment_index,
    input  logic signed [31:0]    operand_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [5:0]            out_spline,
    output logic signed [31:0]    weight,
    output logic                  last_weight
    );

    localparam int SW     = (NUM_SPLINES > 1) ? $clog2(NUM_SPLINES) : 1;
    localparam int KW     = $clog2(NUM_KNOTS);
    localparam int CAW    = SW + KW;
    localparam int CDEPTH = 1 << CAW;
    localparam int KDEPTH = 1 << KW;
    localparam int CMP_W  = 9;

    typedef enum logic [2:0] {ST_IDLE, ST_KNOT, ST_RUN, ST_DRAIN, ST_LOAD} state_t;

    state_t                state_reg, state_next;
    logic [SW-1:0]         spl_cnt_reg, spl_cnt_next;
    logic [KW-1:0]         seg_reg, seg_next;
    logic signed [Q_W-1:0] operand_reg, operand_next;
    logic [1:0]            sel_reg, sel_next;
    logic [CAW-1:0]        load_addr_reg, load_addr_next;
    logic signed [Q_W-1:0] dx_reg, dx_next;

    logic                  accept;
    logic                  adv;
    logic                  spline_ok, knot_ok;
    logic [KW-1:0]         seg_eff;
    logic [SW-1:0]         spl_in;
    logic [KW-1:0]         knot_in;
    logic                  issue_valid;
    logic                  issue_last;
    tag_t                  issue_tag;

    logic                  crd_en, cwr_en;
    logic [CAW-1:0]        crd_addr;
    logic [ROW_W-1:0]      crow, cwr_row;
    logic                  kwr_en, krd_en;
    logic [Q_W-1:0]        kpos;

    logic                  pipe_busy;
    logic                  pipe_valid;
    tag_t                  pipe_tag;
    logic signed [Q_W-1:0] pipe_weight;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign adv      = !pipe_valid || !out_stall;

    assign spline_ok = ({1'b0, spline_index} < 7'(NUM_SPLINES));
    assign knot_ok   = (CMP_W'(knot_index) < CMP_W'(NUM_KNOTS));
    assign seg_eff   = (CMP_W'(segment_index) < CMP_W'(NUM_KNOTS)) ?
                       KW'(segment_index) : KW'(NUM_KNOTS - 1);
    assign spl_in    = SW'(spline_index);
    assign knot_in   = KW'(knot_index);

    assign issue_valid      = (state_reg == ST_RUN);
    assign issue_last       = (spl_cnt_reg == SW'(NUM_SPLINES - 1));
    assign issue_tag.spline = SPL_OUT_W'(spl_cnt_reg);
    assign issue_tag.last   = issue_last;

    // The read port serves the row sweep of an evaluation and the read half of a load.
    always_comb
    begin
        crd_en   = 1'b0;
        crd_addr = {spl_in, knot_in};
        if (state_reg == ST_RUN)
        begin
            crd_en   = adv;
            crd_addr = {spl_cnt_reg, seg_reg};
        end
        else if (accept && cmd == CMD_LOAD_COEF && spline_ok && knot_ok)
        begin
            crd_en = 1'b1;
        end
    end

    always_comb
    begin
        cwr_en  = (state_reg == ST_LOAD);
        cwr_row = crow;
        for (int k = 0; k < COEFFS; k++)
        begin
            if (2'(k) == sel_reg)
            begin
                cwr_row[k*Q_W +: Q_W] = operand_reg;
            end
        end
    end

    assign kwr_en = accept && cmd == CMD_LOAD_KNOT && knot_ok;
    assign krd_en = accept && cmd == CMD_EVAL;

    always_comb
    begin
        state_next     = state_reg;
        spl_cnt_next   = spl_cnt_reg;
        seg_next       = seg_reg;
        operand_next   = operand_reg;
        sel_next       = sel_reg;
        load_addr_next = load_addr_reg;
        dx_next        = dx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    operand_next   = operand_value;
                    seg_next       = seg_eff;
                    sel_next       = coeff_select;
                    load_addr_next = {spl_in, knot_in};
                    case (cmd)
                        CMD_EVAL:
                        begin
                            state_next = ST_KNOT;
                        end
                        CMD_LOAD_COEF:
                        begin
                            if (spline_ok && knot_ok)
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KNOT:
            begin
                dx_next      = q_sat33({operand_reg[Q_W-1], operand_reg} -
                                       {kpos[Q_W-1], kpos});
                spl_cnt_next = '0;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (issue_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        spl_cnt_next = spl_cnt_reg + SW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                // dx must stay put until every row in flight has used it.
                if (!pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spl_cnt_reg   <= '0;
            seg_reg       <= '0;
            operand_reg   <= '0;
            sel_reg       <= '0;
            load_addr_reg <= '0;
            dx_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            spl_cnt_reg   <= spl_cnt_next;
            seg_reg       <= seg_next;
            operand_reg   <= operand_next;
            sel_reg       <= sel_next;
            load_addr_reg <= load_addr_next;
            dx_reg        <= dx_next;
        end
    end

    csbe_ram #(.WIDTH(ROW_W), .DEPTH(CDEPTH)) u_coef_ram (
        .clk     (clk),
        .wr_en   (cwr_en),
        .wr_addr (load_addr_reg),
        .wr_data (cwr_row),
        .rd_en   (crd_en),
        .rd_addr (crd_addr),
        .rd_data (crow)
    );

    csbe_ram #(.WIDTH(Q_W), .DEPTH(KDEPTH)) u_knot_ram (
        .clk     (clk),
        .wr_en   (kwr_en),
        .wr_addr (knot_in),
        .wr_data (operand_value),
        .rd_en   (krd_en),
        .rd_addr (seg_eff),
        .rd_data (kpos)
    );

    csbe_horner u_horner (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .row         (crow),
        .dx          (dx_reg),
        .busy        (pipe_busy),
        .out_valid   (pipe_valid),
        .out_tag     (pipe_tag),
        .weight      (pipe_weight)
    );

    assign out_valid   = pipe_valid;
    assign out_spline  = pipe_tag.spline;
    assign last_weight = pipe_tag.last;
    assign weight      = pipe_weight;

    // No new transaction may enter while rows are still in the Horner pipeline ahead of its output stage.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_busy |-> in_stall)
        else $error("transaction accepted while pipeline busy");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_weight) |-> (out_spline == SPL_OUT_W'(NUM_SPLINES - 1)))
        else $error("last weight flagged on wrong spline");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (spl_cnt_reg <= SW'(NUM_SPLINES - 1)))
        else $error("spline counter ran past the bank");

    a_load_back: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_IDLE))
        else $error("coefficient write-back did not complete");

endmodule
